### hdl/lmd_pkg.sv
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared types and constants of the liftoff detector.
// ----------------------------------------------------------------------------
`default_nettype none

package lmd_pkg;

  localparam int WLEN_BITS  = 7;
  localparam int THR_BITS   = 5;
  localparam int REQ_BITS   = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_ADDR_W = 2;

  localparam int MAG_BITS   = 5;
  localparam int SUM_BITS   = 11;
  localparam int CNT_BITS   = 8;
  localparam int MAX_WINDOW = 64;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MEAN_THRESHOLD   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOWS_REQUIRED = 2'd2;

  localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd20;
  localparam logic [THR_BITS-1:0]  THR_RESET  = 5'd1;
  localparam logic [REQ_BITS-1:0]  REQ_RESET  = 8'd3;

  typedef struct packed {
    logic [WLEN_BITS-1:0] window_length;
    logic [THR_BITS-1:0]  mean_threshold;
    logic [REQ_BITS-1:0]  windows_required;
  } lmd_cfg_t;

  // one result beat
  typedef struct packed {
    logic [CNT_BITS-1:0] detection_count;
    logic                liftoff_latched;
    logic                liftoff_event;
    logic                window_above;
    logic                window_done;
    logic [MAG_BITS-1:0] magnitude_g;
  } lmd_result_t;

endpackage

`default_nettype wire

### hdl/lmd_fifo.sv
// ----------------------------------------------------------------------------
// lmd_fifo
// Two-entry queue between the squaring front and the root/window back.
// ----------------------------------------------------------------------------
`default_nettype none

module lmd_fifo #(
  parameter int WIDTH = 33
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  wire [WIDTH-1:0]  push_data,
  output logic             pop_valid,
  input  wire              pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push_fire, pop_fire;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push_fire ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_fire ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 2'd1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hdl/lmd_front.sv
// ----------------------------------------------------------------------------
// lmd_front
// Takes a sample beat and forms x*x + y*y + z*z on one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module lmd_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        smp_valid,
  output logic                       smp_ready,
  input  wire signed [SAMPLE_BITS-1:0] smp_x,
  input  wire signed [SAMPLE_BITS-1:0] smp_y,
  input  wire signed [SAMPLE_BITS-1:0] smp_z,
  input  wire                        smp_clear,
  output logic                       push_valid,
  input  wire                        push_ready,
  output logic [2*SAMPLE_BITS:0]     push_data
);

  localparam int SQ_BITS = 2 * SAMPLE_BITS;

  localparam logic [1:0] PH_X    = 2'd0;
  localparam logic [1:0] PH_Y    = 2'd1;
  localparam logic [1:0] PH_Z    = 2'd2;
  localparam logic [1:0] PH_PUSH = 2'd3;

  logic signed [SAMPLE_BITS-1:0] x_r, y_r, z_r;
  logic                          clear_r;
  logic                          busy_r, busy_nxt;
  logic [1:0]                    phase_r, phase_nxt;
  logic [SQ_BITS-1:0]            acc_r, acc_nxt;
  logic signed [SAMPLE_BITS-1:0] operand;
  logic signed [SQ_BITS-1:0]     square;
  logic                          take;

  assign smp_ready  = !busy_r;
  assign take       = smp_valid && !busy_r;
  assign push_valid = busy_r && (phase_r == PH_PUSH);
  assign push_data  = {clear_r, acc_r};

  always_comb begin
    case (phase_r)
      PH_X:    operand = x_r;
      PH_Y:    operand = y_r;
      PH_Z:    operand = z_r;
      default: operand = x_r;
    endcase
  end

  assign square = SQ_BITS'(operand) * SQ_BITS'(operand);

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    if (take) begin
      busy_nxt  = 1'b1;
      phase_nxt = PH_X;
      acc_nxt   = '0;
    end else if (busy_r) begin
      if (phase_r != PH_PUSH) begin
        acc_nxt   = acc_r + $unsigned(square);
        phase_nxt = phase_r + 2'd1;
      end else if (push_ready) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_X;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (take) begin
      x_r     <= smp_x;
      y_r     <= smp_y;
      z_r     <= smp_z;
      clear_r <= smp_clear;
    end
  end

endmodule

`default_nettype wire

### hdl/lmd_back.sv
// ----------------------------------------------------------------------------
// lmd_back
// Bit-pair square root, window averaging and liftoff decision.
// ----------------------------------------------------------------------------
`default_nettype none

module lmd_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  lmd_pkg::lmd_cfg_t         cfg,
  input  wire                       pop_valid,
  output logic                      pop_ready,
  input  wire [2*SAMPLE_BITS:0]     pop_data,
  output logic                      res_valid,
  input  wire                       res_ready,
  output lmd_pkg::lmd_result_t      res_data
);
  import lmd_pkg::*;

  localparam int SQ_BITS  = 2 * SAMPLE_BITS;
  localparam int REM_BITS = SAMPLE_BITS + 2;
  localparam int STEP_W   = $clog2(SAMPLE_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [SQ_BITS-1:0]     rad_r, rad_nxt;
  logic [REM_BITS-1:0]    rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] root_r, root_nxt;
  logic                   clear_r, clear_nxt;

  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [WLEN_BITS-1:0]   idx_r, idx_nxt;
  logic [CNT_BITS-1:0]    pass_r, pass_nxt;
  logic                   flag_r, flag_nxt;
  logic [CNT_BITS-1:0]    total_r, total_nxt;

  logic                   res_valid_r, res_valid_nxt;
  lmd_result_t            res_r, res_nxt;

  logic [REM_BITS-1:0]    rem_sh, trial;
  logic                   ge;
  logic [MAG_BITS-1:0]    mag;
  logic [WLEN_BITS-1:0]   len_eff;
  logic [SUM_BITS-1:0]    sum_add;
  logic                   done, above, event_hit;
  logic [THR_BITS:0]      thr_p1;
  logic [12:0]            bound;
  logic [CNT_BITS-1:0]    pass_inc;
  logic                   upd_fire, latched;

  assign pop_ready = (state_r == ST_IDLE);
  assign res_valid = res_valid_r;
  assign res_data  = res_r;

  // one result bit per step: shift in the next two radicand bits
  assign rem_sh = {rem_r[SAMPLE_BITS-1:0], rad_r[SQ_BITS-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  assign mag = root_r[SAMPLE_BITS-1 -: MAG_BITS];

  always_comb begin
    if (cfg.window_length == '0) begin
      len_eff = WLEN_BITS'(1);
    end else if (cfg.window_length > WLEN_BITS'(MAX_WINDOW)) begin
      len_eff = WLEN_BITS'(MAX_WINDOW);
    end else begin
      len_eff = cfg.window_length;
    end
  end

  assign sum_add  = sum_r + SUM_BITS'(mag);
  assign done     = ({1'b0, idx_r} + 8'd1) >= {1'b0, len_eff};
  // sum / len > thr  <=>  sum >= (thr + 1) * len
  assign thr_p1   = {1'b0, cfg.mean_threshold} + 6'd1;
  assign bound    = 13'(thr_p1) * 13'(len_eff);
  assign above    = done && (13'(sum_add) >= bound);
  assign pass_inc = pass_r + 8'd1;
  assign event_hit = above && (pass_r != 8'hFF) && (pass_inc == cfg.windows_required);
  assign upd_fire = (state_r == ST_UPD) && (!res_valid_r || res_ready);
  assign latched  = flag_r || event_hit;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    clear_nxt     = clear_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    pass_nxt      = pass_r;
    flag_nxt      = flag_r;
    total_nxt     = total_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;

    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          rad_nxt   = pop_data[SQ_BITS-1:0];
          clear_nxt = pop_data[SQ_BITS];
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = STEP_W'(SAMPLE_BITS - 1);
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
        root_nxt = {root_r[SAMPLE_BITS-2:0], ge};
        rad_nxt  = {rad_r[SQ_BITS-3:0], 2'b00};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_fire) begin
          if (done) begin
            sum_nxt = '0;
            idx_nxt = '0;
            if (above) begin
              if (pass_r != 8'hFF) begin
                pass_nxt = pass_inc;
              end
            end else begin
              pass_nxt = '0;
            end
          end else begin
            sum_nxt = sum_add;
            idx_nxt = idx_r + WLEN_BITS'(1);
          end
          if (event_hit && (total_r != 8'hFF)) begin
            total_nxt = total_r + 8'd1;
          end
          // a clear in the same beat still shows the flag, then drops it
          flag_nxt = latched && !clear_r;

          res_nxt.magnitude_g     = mag;
          res_nxt.window_done     = done;
          res_nxt.window_above    = above;
          res_nxt.liftoff_event   = event_hit;
          res_nxt.liftoff_latched = latched;
          res_nxt.detection_count = (event_hit && (total_r != 8'hFF)) ?
                                    total_r + 8'd1 : total_r;
          res_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      idx_r       <= '0;
      pass_r      <= '0;
      flag_r      <= 1'b0;
      total_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      pass_r      <= pass_nxt;
      flag_r      <= flag_nxt;
      total_r     <= total_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    rad_r   <= rad_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    clear_r <= clear_nxt;
    res_r   <= res_nxt;
  end

endmodule

`default_nettype wire

### hdl/accel_magnitude_liftoff_detector_top.sv
// Each sample beat passes through the back end in order: it is taken from the
// queue as a squared magnitude, the two-bits-per-step square root yields one
// result bit per step, then the window and liftoff update runs. The front end
// takes the beat, forms three squares on one shared multiplier, then hands off.
// Each end takes a new beat only once it is through with the last; a two-entry
// queue sits between them, so the square root loop sets the sustained rate.
// Results leave through an output register, one result beat per sample beat, in
// order; tlast marks the beat that closed an averaging window.
// ----------------------------------------------------------------------------
// accel_magnitude_liftoff_detector_top
// Acceleration magnitude threshold liftoff detector, stream in and out.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_magnitude_liftoff_detector_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // accel_x, accel_y, accel_z (SAMPLE_BITS each), clear_latch, zero fill
  input  wire [((3*SAMPLE_BITS+1+7)/8)*8-1:0] in_tdata,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // magnitude_g[4:0], window_above, liftoff_event, liftoff_latched,
  // detection_count[7:0]
  output logic [15:0]                        out_tdata,
  // window_done
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  input  wire                                cfg_we,
  input  wire [lmd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire [lmd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lmd_pkg::*;

  localparam int Q_WIDTH = 2 * SAMPLE_BITS + 1;

  lmd_cfg_t    cfg_r;
  lmd_result_t res;

  logic               push_valid, push_ready;
  logic [Q_WIDTH-1:0] push_data;
  logic               pop_valid, pop_ready;
  logic [Q_WIDTH-1:0] pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length    <= WLEN_RESET;
      cfg_r.mean_threshold   <= THR_RESET;
      cfg_r.windows_required <= REQ_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WINDOW_LENGTH:    cfg_r.window_length    <= cfg_data[WLEN_BITS-1:0];
        REG_MEAN_THRESHOLD:   cfg_r.mean_threshold   <= cfg_data[THR_BITS-1:0];
        REG_WINDOWS_REQUIRED: cfg_r.windows_required <= cfg_data[REQ_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  lmd_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .smp_valid  (in_tvalid),
    .smp_ready  (in_tready),
    .smp_x      (in_tdata[SAMPLE_BITS-1:0]),
    .smp_y      (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .smp_z      (in_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .smp_clear  (in_tdata[3*SAMPLE_BITS]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lmd_fifo #(
    .WIDTH(Q_WIDTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lmd_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_data  (res)
  );

  assign out_tdata = {res.detection_count, res.liftoff_latched, res.liftoff_event,
                      res.window_above, res.magnitude_g};
  assign out_tlast = res.window_done;

endmodule

`default_nettype wire
